// ===== sv/mrr_pkg.sv =====
// Shared constants, codes and types of the multi-reader record ring.
`timescale 1ns / 1ps
package mrr_pkg;

    localparam int BUFFER_BYTES = 4096;
    localparam int READERS      = 8;
    localparam int MAX_RECORD   = 512;
    localparam int HDR_BYTES    = 8;

    localparam int ADDR_W     = $clog2(BUFFER_BYTES);
    localparam int LEN_W      = ADDR_W + 2;
    localparam int NBANK      = 8;
    localparam int BANK_AW    = ADDR_W - 3;
    localparam int BANK_DEPTH = BUFFER_BYTES / NBANK;
    localparam int CNT_W      = $clog2(MAX_RECORD + 1);
    localparam int OFF_W      = CNT_W + 1;
    localparam int STG_WORDS  = (MAX_RECORD + 7) / 8;
    localparam int STG_AW     = (STG_WORDS > 1) ? $clog2(STG_WORDS) : 1;
    localparam int RID_W      = (READERS > 1) ? $clog2(READERS) : 1;
    localparam int MAX_PASSES = 8;
    localparam int PASS_W     = 4;

    // action codes
    localparam logic [2:0] ACT_APPEND  = 3'd0;
    localparam logic [2:0] ACT_CLAIM   = 3'd1;
    localparam logic [2:0] ACT_RELEASE = 3'd2;
    localparam logic [2:0] ACT_READ    = 3'd3;
    localparam logic [2:0] ACT_CLEAR   = 3'd4;

    // status codes
    localparam logic [3:0] ST_APPENDED   = 4'd0;
    localparam logic [3:0] ST_GRANTED    = 4'd1;
    localparam logic [3:0] ST_NONE_FREE  = 4'd2;
    localparam logic [3:0] ST_RELEASED   = 4'd3;
    localparam logic [3:0] ST_NO_DATA    = 4'd4;
    localparam logic [3:0] ST_TOO_LONG   = 4'd5;
    localparam logic [3:0] ST_DATA       = 4'd6;
    localparam logic [3:0] ST_CLEARED    = 4'd7;
    localparam logic [3:0] ST_DROPPED    = 4'd8;
    localparam logic [3:0] ST_BAD_READER = 4'd9;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_DISPATCH, S_CLEAR, S_EMIT,
        S_P_RD, S_P_CHK, S_M_STEP, S_M_ACC, S_W_WR0,
        S_PL_HDRN, S_PL_DATA, S_PL_HDRW,
        S_RD_HDR, S_RD_HDRW, S_RD_ISSUE, S_RD_DATA
    } state_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } store_rd_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [63:0]       data;
        logic [7:0]        mask;
    } store_wr_t;

endpackage

// ===== sv/multi_reader_record_ring_top.sv =====
// Top level of the multi-reader record ring: command sequencer, cursors and output register.
`timescale 1ns / 1ps
// Keeps a ring of variable-length records in a 4096-byte banked store (8-byte
// read and masked write per cycle, registered read data), each record behind
// an 8-byte header {length, free length}. One transaction is taken at a time:
// s_tready is high only while the sequencer is idle, but a finished result may
// still sit in the output register while the next transaction is accepted.
// Closing a record reads the header at the write point, merges the blocks
// ahead of it or wraps to the start until the free length fits, re-reading
// the header after each merge run or wrap, then writes the new free header,
// the data from staging in 8-byte words and the record header.
// A read visits headers until it finds a record, then streams it as 8-byte
// results, each store read issued only while the output register is free, so
// a stalled receiver holds the read. Other results are single status results.
// After reset the header at address zero is written before the first
// transaction is taken.
module multi_reader_record_ring_top import mrr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata: data_byte[7:0], has_byte[8], reader_id[11:9], read_capacity[21:12]
    input  logic [23:0] s_tdata,
    // s_tuser: action[2:0]
    input  logic [2:0]  s_tuser,
    input  logic        s_tlast,    // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata: granted_reader[2:0], record_length[12:3], out_data[76:13],
    //          byte_count[80:77]
    output logic [87:0] m_tdata,
    // m_tuser: status[3:0]
    output logic [3:0]  m_tuser,
    output logic        m_tlast     // last_result
);

    localparam logic [LEN_W-1:0] BUF_L = LEN_W'(BUFFER_BYTES);
    localparam logic [LEN_W-1:0] HDR_L = LEN_W'(HDR_BYTES);

    state_t state_reg, state_next;

    // captured transaction
    logic [2:0]  act_reg, act_next;
    logic [7:0]  byte_reg, byte_next;
    logic        has_reg, has_next;
    logic        last_reg, last_next;
    logic [2:0]  rid_reg, rid_next;
    logic [9:0]  cap_reg, cap_next;

    // ring state
    logic [ADDR_W-1:0] wp_reg, wp_next;
    logic [READERS-1:0] claimed_reg, claimed_next;
    logic [ADDR_W-1:0] rp_reg [READERS];
    logic [ADDR_W-1:0] rp_next [READERS];
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              ovf_reg, ovf_next;

    // placement
    logic [CNT_W-1:0]  plen_reg, plen_next;
    logic [ADDR_W-1:0] start_reg, start_next;
    logic              all_reg, all_next;
    logic [PASS_W-1:0] pass_reg, pass_next;
    logic [LEN_W-1:0]  fr_reg, fr_next;
    logic [LEN_W-1:0]  lenwp_reg, lenwp_next;
    logic [LEN_W-1:0]  nxt_reg, nxt_next;
    logic [OFF_W-1:0]  off_reg, off_next;

    // read walk
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [LEN_W-1:0]  rlen_reg, rlen_next;
    logic [ADDR_W-1:0] np_reg, np_next;

    // pending single result
    logic [3:0] em_st_reg, em_st_next;
    logic [2:0] em_gr_reg, em_gr_next;
    logic [9:0] em_len_reg, em_len_next;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [3:0]  m_st_reg, m_st_next;
    logic [2:0]  m_gr_reg, m_gr_next;
    logic [9:0]  m_len_reg, m_len_next;
    logic [63:0] m_data_reg, m_data_next;
    logic [3:0]  m_cnt_reg, m_cnt_next;
    logic        m_last_reg, m_last_next;

    store_rd_t   st_rd;
    store_wr_t   st_wr;
    logic [63:0] st_q;

    logic              stg_wen;
    logic [STG_AW-1:0] stg_widx;
    logic              stg_ren;
    logic [STG_AW-1:0] stg_ridx;
    logic [63:0]       stg_q;

    mrr_store u_store (
        .aclk    (aclk),
        .rd      (st_rd),
        .wr      (st_wr),
        .rd_data (st_q)
    );

    mrr_staging u_staging (
        .aclk  (aclk),
        .wen   (stg_wen),
        .widx  (stg_widx),
        .wlane (cnt_reg[2:0]),
        .wbyte (byte_reg),
        .ren   (stg_ren),
        .ridx  (stg_ridx),
        .rdata (stg_q)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_cnt_reg, m_data_reg, m_len_reg, m_gr_reg};
    assign m_tuser  = m_st_reg;
    assign m_tlast  = m_last_reg;

    assign stg_widx = cnt_reg[STG_AW+2:3];

    always_comb begin
        logic              out_free;
        logic [LEN_W-1:0]  hlen, hfree, need, nx, fr_sum, hend, e;
        logic [ADDR_W-1:0] hnext, npos;
        logic              rid_bad, has_keep, ovf_eff, found;
        logic [CNT_W-1:0]  cnt_eff;
        logic [RID_W-1:0]  rid_idx, free_idx;
        logic [OFF_W-1:0]  rem, off_plus;
        logic [3:0]        chunk;
        logic [63:0]       dmask;

        state_next   = state_reg;
        act_next     = act_reg;
        byte_next    = byte_reg;
        has_next     = has_reg;
        last_next    = last_reg;
        rid_next     = rid_reg;
        cap_next     = cap_reg;
        wp_next      = wp_reg;
        claimed_next = claimed_reg;
        rp_next      = rp_reg;
        cnt_next     = cnt_reg;
        ovf_next     = ovf_reg;
        plen_next    = plen_reg;
        start_next   = start_reg;
        all_next     = all_reg;
        pass_next    = pass_reg;
        fr_next      = fr_reg;
        lenwp_next   = lenwp_reg;
        nxt_next     = nxt_reg;
        off_next     = off_reg;
        pos_next     = pos_reg;
        rlen_next    = rlen_reg;
        np_next      = np_reg;
        em_st_next   = em_st_reg;
        em_gr_next   = em_gr_reg;
        em_len_next  = em_len_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_st_next    = m_st_reg;
        m_gr_next    = m_gr_reg;
        m_len_next   = m_len_reg;
        m_data_next  = m_data_reg;
        m_cnt_next   = m_cnt_reg;
        m_last_next  = m_last_reg;

        st_rd    = '0;
        st_wr    = '0;
        stg_wen  = 1'b0;
        stg_ren  = 1'b0;
        stg_ridx = '0;

        out_free = !m_valid_reg || m_tready;
        hlen     = LEN_W'(st_q[31:0]);
        hfree    = LEN_W'(st_q[63:32]);
        need     = LEN_W'(plen_reg) + HDR_L;
        nx       = LEN_W'(wp_reg) + HDR_L + lenwp_reg + fr_reg;
        fr_sum   = fr_reg + HDR_L + hlen + hfree;
        hend     = LEN_W'(pos_reg) + HDR_L + hlen + hfree;
        hnext    = (hend >= BUF_L) ? '0 : hend[ADDR_W-1:0];
        // end of the free block at the new write point (wrapped to zero
        // when the record fills its block right up to the end of the store)
        e        = ((nxt_reg >= BUF_L) ? '0 : nxt_reg) + HDR_L + (fr_reg - need);
        npos     = (e >= BUF_L) ? '0 : e[ADDR_W-1:0];
        rid_bad  = 32'(rid_reg) >= READERS;
        rid_idx  = RID_W'(rid_reg);
        has_keep = has_reg && (32'(cnt_reg) < MAX_RECORD);
        cnt_eff  = cnt_reg + CNT_W'(has_keep);
        ovf_eff  = ovf_reg || (has_reg && !has_keep);
        off_plus = off_reg + OFF_W'(8);

        // lowest free reader slot
        found    = 1'b0;
        free_idx = '0;
        for (int i = READERS - 1; i >= 0; i--) begin
            if (!claimed_reg[i]) begin
                found    = 1'b1;
                free_idx = RID_W'(i);
            end
        end

        rem   = (state_reg == S_PL_DATA) ? (OFF_W'(plen_reg) - off_reg)
                                         : (OFF_W'(rlen_reg) - off_reg);
        chunk = (rem >= OFF_W'(8)) ? 4'd8 : rem[3:0];
        for (int k = 0; k < 8; k++) begin
            dmask[8*k +: 8] = (4'(k) < chunk) ? 8'hFF : 8'h00;
        end

        case (state_reg)
            S_INIT: begin
                st_wr.en   = 1'b1;
                st_wr.addr = '0;
                st_wr.data = {32'(BUFFER_BYTES - HDR_BYTES), 32'd0};
                st_wr.mask = 8'hFF;
                state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    act_next   = s_tuser;
                    byte_next  = s_tdata[7:0];
                    has_next   = s_tdata[8];
                    rid_next   = s_tdata[11:9];
                    cap_next   = s_tdata[21:12];
                    last_next  = s_tlast;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                em_gr_next  = '0;
                em_len_next = '0;
                state_next  = S_EMIT;
                case (act_reg)
                    ACT_APPEND: begin
                        stg_wen = has_keep;
                        if (last_reg) begin
                            cnt_next = '0;
                            ovf_next = 1'b0;
                            if (ovf_eff ||
                                (LEN_W'(cnt_eff) + 2 * HDR_L > BUF_L)) begin
                                em_st_next = ST_DROPPED;
                            end else begin
                                plen_next  = cnt_eff;
                                start_next = wp_reg;
                                all_next   = 1'b0;
                                pass_next  = '0;
                                state_next = S_P_RD;
                            end
                        end else begin
                            cnt_next   = cnt_eff;
                            ovf_next   = ovf_eff;
                            em_st_next = ST_APPENDED;
                        end
                    end
                    ACT_CLAIM: begin
                        if (found) begin
                            claimed_next[free_idx] = 1'b1;
                            rp_next[free_idx]      = wp_reg;
                            em_st_next             = ST_GRANTED;
                            em_gr_next             = 3'(free_idx);
                        end else begin
                            em_st_next = ST_NONE_FREE;
                        end
                    end
                    ACT_RELEASE: begin
                        if (rid_bad) begin
                            em_st_next = ST_BAD_READER;
                        end else begin
                            claimed_next[rid_idx] = 1'b0;
                            em_st_next            = ST_RELEASED;
                        end
                    end
                    ACT_READ: begin
                        if (rid_bad) begin
                            em_st_next = ST_BAD_READER;
                        end else if (rp_reg[rid_idx] == wp_reg) begin
                            em_st_next = ST_NO_DATA;
                        end else begin
                            pos_next   = rp_reg[rid_idx];
                            state_next = S_RD_HDR;
                        end
                    end
                    ACT_CLEAR: begin
                        state_next = S_CLEAR;
                    end
                    default: begin
                        state_next = S_IDLE;    // undefined action: no result
                    end
                endcase
            end
            S_CLEAR: begin
                st_wr.en     = 1'b1;
                st_wr.addr   = '0;
                st_wr.data   = {32'(BUFFER_BYTES - HDR_BYTES), 32'd0};
                st_wr.mask   = 8'hFF;
                claimed_next = '0;
                for (int i = 0; i < READERS; i++) begin
                    rp_next[i] = '0;
                end
                wp_next    = '0;
                cnt_next   = '0;
                ovf_next   = 1'b0;
                em_st_next = ST_CLEARED;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_st_next    = em_st_reg;
                    m_gr_next    = em_gr_reg;
                    m_len_next   = em_len_reg;
                    m_data_next  = '0;
                    m_cnt_next   = '0;
                    m_last_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            // placement: one pass per header read at the write point
            S_P_RD: begin
                if (32'(pass_reg) >= MAX_PASSES) begin
                    em_st_next = ST_DROPPED;
                    state_next = S_EMIT;
                end else begin
                    st_rd.en   = 1'b1;
                    st_rd.addr = wp_reg;
                    state_next = S_P_CHK;
                end
            end
            S_P_CHK: begin
                fr_next    = hfree;
                lenwp_next = hlen;
                if (hfree >= need) begin
                    nxt_next   = LEN_W'(wp_reg) + HDR_L + LEN_W'(plen_reg);
                    state_next = S_PL_HDRN;
                end else begin
                    state_next = S_M_STEP;
                end
            end
            S_M_STEP: begin
                if (nx == LEN_W'(start_reg)) begin
                    all_next = 1'b1;
                end
                st_rd.en = 1'b1;
                if (nx >= BUF_L) begin
                    // ran off the end: wrap and fold the block at zero
                    wp_next    = '0;
                    st_rd.addr = '0;
                    state_next = S_W_WR0;
                end else begin
                    st_rd.addr = nx[ADDR_W-1:0];
                    state_next = S_M_ACC;
                end
            end
            S_M_ACC: begin
                fr_next    = fr_sum;
                st_wr.en   = 1'b1;
                st_wr.addr = wp_reg;
                st_wr.data = {32'(fr_sum), 32'd0};
                st_wr.mask = 8'hF0;
                if (fr_sum >= need) begin
                    pass_next  = pass_reg + 1'b1;
                    state_next = S_P_RD;
                end else begin
                    state_next = S_M_STEP;
                end
            end
            S_W_WR0: begin
                st_wr.en   = 1'b1;
                st_wr.addr = '0;
                st_wr.data = {32'(hfree + hlen), 32'd0};
                st_wr.mask = 8'hFF;
                pass_next  = pass_reg + 1'b1;
                state_next = S_P_RD;
            end
            S_PL_HDRN: begin
                st_wr.en   = 1'b1;
                st_wr.addr = nxt_reg[ADDR_W-1:0];
                st_wr.data = {32'(fr_reg - need), 32'd0};
                st_wr.mask = 8'hFF;
                stg_ren    = 1'b1;
                stg_ridx   = '0;
                off_next   = '0;
                state_next = S_PL_DATA;
            end
            S_PL_DATA: begin
                if (off_reg < OFF_W'(plen_reg)) begin
                    st_wr.en   = 1'b1;
                    st_wr.addr = ADDR_W'(LEN_W'(wp_reg) + HDR_L + LEN_W'(off_reg));
                    st_wr.data = stg_q;
                    for (int k = 0; k < 8; k++) begin
                        st_wr.mask[k] = dmask[8*k];
                    end
                    stg_ren  = 1'b1;
                    stg_ridx = off_plus[STG_AW+2:3];
                    off_next = off_plus;
                end else begin
                    state_next = S_PL_HDRW;
                end
            end
            S_PL_HDRW: begin
                st_wr.en   = 1'b1;
                st_wr.addr = wp_reg;
                st_wr.data = {32'd0, 32'(plen_reg)};
                st_wr.mask = 8'hFF;
                wp_next    = (nxt_reg >= BUF_L) ? '0 : nxt_reg[ADDR_W-1:0];
                // cursors inside the overwritten span jump to the new free end
                for (int i = 0; i < READERS; i++) begin
                    if (all_reg) begin
                        rp_next[i] = npos;
                    end else if (npos > start_reg) begin
                        if (rp_reg[i] > start_reg && rp_reg[i] < npos) begin
                            rp_next[i] = npos;
                        end
                    end else if (rp_reg[i] > start_reg || rp_reg[i] < npos) begin
                        rp_next[i] = npos;
                    end
                end
                em_st_next = ST_APPENDED;
                state_next = S_EMIT;
            end
            // read: walk empty blocks, then stream the record
            S_RD_HDR: begin
                st_rd.en   = 1'b1;
                st_rd.addr = pos_reg;
                state_next = S_RD_HDRW;
            end
            S_RD_HDRW: begin
                if (hlen == '0) begin
                    if (pos_reg == wp_reg) begin
                        em_st_next = ST_NO_DATA;
                        state_next = S_EMIT;
                    end else begin
                        pos_next   = hnext;
                        state_next = S_RD_HDR;
                    end
                end else begin
                    rlen_next = hlen;
                    np_next   = hnext;
                    off_next  = '0;
                    if (hlen > LEN_W'(cap_reg) || hlen > LEN_W'(MAX_RECORD)) begin
                        rp_next[rid_idx] = hnext;
                        em_st_next       = ST_TOO_LONG;
                        em_len_next      = hlen[9:0];
                        state_next       = S_EMIT;
                    end else begin
                        state_next = S_RD_ISSUE;
                    end
                end
            end
            S_RD_ISSUE: begin
                if (out_free) begin
                    st_rd.en   = 1'b1;
                    st_rd.addr = ADDR_W'(LEN_W'(pos_reg) + HDR_L + LEN_W'(off_reg));
                    state_next = S_RD_DATA;
                end
            end
            S_RD_DATA: begin
                m_valid_next = 1'b1;
                m_st_next    = ST_DATA;
                m_gr_next    = '0;
                m_len_next   = rlen_reg[9:0];
                m_data_next  = st_q & dmask;
                m_cnt_next   = chunk;
                m_last_next  = (LEN_W'(off_plus) >= rlen_reg);
                off_next     = off_plus;
                if (LEN_W'(off_plus) >= rlen_reg) begin
                    rp_next[rid_idx] = np_reg;
                    state_next       = S_IDLE;
                end else begin
                    state_next = S_RD_ISSUE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            wp_reg      <= '0;
            claimed_reg <= '0;
            for (int i = 0; i < READERS; i++) begin
                rp_reg[i] <= '0;
            end
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            pass_reg    <= '0;
            all_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            claimed_reg <= claimed_next;
            rp_reg      <= rp_next;
            cnt_reg     <= cnt_next;
            ovf_reg     <= ovf_next;
            pass_reg    <= pass_next;
            all_reg     <= all_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        act_reg    <= act_next;
        byte_reg   <= byte_next;
        has_reg    <= has_next;
        last_reg   <= last_next;
        rid_reg    <= rid_next;
        cap_reg    <= cap_next;
        plen_reg   <= plen_next;
        start_reg  <= start_next;
        fr_reg     <= fr_next;
        lenwp_reg  <= lenwp_next;
        nxt_reg    <= nxt_next;
        off_reg    <= off_next;
        pos_reg    <= pos_next;
        rlen_reg   <= rlen_next;
        np_reg     <= np_next;
        em_st_reg  <= em_st_next;
        em_gr_reg  <= em_gr_next;
        em_len_reg <= em_len_next;
        m_st_reg   <= m_st_next;
        m_gr_reg   <= m_gr_next;
        m_len_reg  <= m_len_next;
        m_data_reg <= m_data_next;
        m_cnt_reg  <= m_cnt_next;
        m_last_reg <= m_last_next;
    end

`ifndef SYNTHESIS
    // staging fill never passes the record limit
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(cnt_reg) <= MAX_RECORD)
        else $error("staging count beyond limit");

    // placement never runs more passes than allowed
    a_pass_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(pass_reg) <= MAX_PASSES)
        else $error("placement pass count beyond limit");

    // only data transactions come in runs; everything else closes at once
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_DATA) |-> m_tlast)
        else $error("non-data result without last flag");

    // a data transaction carries one to eight bytes
    a_data_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ST_DATA) |->
            (m_tdata[80:77] != 4'd0 && m_tdata[80:77] <= 4'd8))
        else $error("data result with bad byte count");
`endif

endmodule

// ===== sv/mrr_store.sv =====
// Record store: eight byte banks giving an 8-byte read and masked write at any byte address.
`timescale 1ns / 1ps
module mrr_store import mrr_pkg::*; (
    input  logic        aclk,
    input  store_rd_t   rd,
    input  store_wr_t   wr,
    output logic [63:0] rd_data
);

    logic [7:0]         mem [NBANK][BANK_DEPTH];
    logic [7:0]         q_reg [NBANK];
    logic [2:0]         rot_reg;
    logic [2:0]         wj [NBANK];
    logic [BANK_AW-1:0] wa [NBANK];
    logic [BANK_AW-1:0] ra [NBANK];

    // bank b holds byte lane (b - addr) mod 8 of the access
    always_comb begin
        logic [ADDR_W-1:0] ws;
        logic [ADDR_W-1:0] rs;
        logic [2:0]        rj;
        for (int b = 0; b < NBANK; b++) begin
            wj[b] = 3'(b) - wr.addr[2:0];
            rj    = 3'(b) - rd.addr[2:0];
            ws    = wr.addr + ADDR_W'(wj[b]);
            rs    = rd.addr + ADDR_W'(rj);
            wa[b] = ws[ADDR_W-1:3];
            ra[b] = rs[ADDR_W-1:3];
        end
    end

    always_ff @(posedge aclk) begin
        for (int b = 0; b < NBANK; b++) begin
            if (wr.en && wr.mask[wj[b]]) begin
                mem[b][wa[b]] <= wr.data[8*wj[b] +: 8];
            end
            if (rd.en) begin
                q_reg[b] <= mem[b][ra[b]];
            end
        end
        if (rd.en) begin
            rot_reg <= rd.addr[2:0];
        end
    end

    always_comb begin
        for (int j = 0; j < 8; j++) begin
            rd_data[8*j +: 8] = q_reg[3'(rot_reg + 3'(j))];
        end
    end

endmodule

// ===== sv/mrr_staging.sv =====
// Staging buffer: byte-wide appends, 8-byte word reads for placement.
`timescale 1ns / 1ps
module mrr_staging import mrr_pkg::*; (
    input  logic              aclk,
    input  logic              wen,
    input  logic [STG_AW-1:0] widx,
    input  logic [2:0]        wlane,
    input  logic [7:0]        wbyte,
    input  logic              ren,
    input  logic [STG_AW-1:0] ridx,
    output logic [63:0]       rdata
);

    logic [63:0] mem [STG_WORDS];
    logic [63:0] q_reg;

    always_ff @(posedge aclk) begin
        if (wen) begin
            mem[widx][8*wlane +: 8] <= wbyte;
        end
        if (ren) begin
            q_reg <= mem[ridx];
        end
    end

    assign rdata = q_reg;

endmodule

// ===== bench/multi_reader_record_ring_top_tb.sv =====
// Self-checking bench for the multi-reader record ring: directed and random transactions against a model.
`timescale 1ns / 1ps
module multi_reader_record_ring_top_tb;
    import mrr_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int ITEMS          = 150;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last_byte;
        logic [2:0] reader_id;
        logic [9:0] read_capacity;
    } cmd_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [2:0]  granted;
        logic [9:0]  rec_len;
        logic [63:0] payload;
        logic [3:0]  nbytes;
        logic        last;
    } resp_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;

    multi_reader_record_ring_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    cmd_t  pending_cmds[$];
    resp_t expected_resps[$];
    int    error_count;
    int    idle_cycles;

    // model state of the ring
    logic [7:0]  ring_mem[BUFFER_BYTES];
    int unsigned wr_ptr;
    int unsigned claimed_mask;
    int unsigned cursor[READERS];
    logic [7:0]  stage_mem[MAX_RECORD];
    int unsigned stage_cnt;
    bit          stage_ovf;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned get32(longint unsigned pos);
        int unsigned v;
        v = 0;
        for (int k = 0; k < 4; k++)
            v |= int'(ring_mem[(pos + k) % BUFFER_BYTES]) << (8 * k);
        return v;
    endfunction

    function automatic void put32(longint unsigned pos, int unsigned v);
        for (int k = 0; k < 4; k++)
            ring_mem[(pos + k) % BUFFER_BYTES] = v[8*k +: 8];
    endfunction

    function automatic longint unsigned block_end(longint unsigned pos);
        return pos + HDR_BYTES + longint'(get32(pos)) + longint'(get32(pos + 4));
    endfunction

    function automatic void push_resp(logic [3:0] st, logic [2:0] gr, logic [9:0] ln,
                                      logic [63:0] d, logic [3:0] n, logic lst);
        resp_t r;
        r = '{status: st, granted: gr, rec_len: ln, payload: d, nbytes: n, last: lst};
        expected_resps.push_back(r);
    endfunction

    function automatic void wipe_ring();
        claimed_mask = 0;
        for (int i = 0; i < READERS; i++) cursor[i] = 0;
        wr_ptr = 0;
        put32(0, 0);
        put32(4, BUFFER_BYTES - HDR_BYTES);
        stage_cnt = 0;
        stage_ovf = 0;
    endfunction

    // returns 1 when the staged record found a home
    function automatic bit place_staged(int unsigned len);
        int unsigned     need, start, fr, np, p;
        bit              all_gone, placed;
        longint unsigned nxt, nx, e;
        need = len + HDR_BYTES;
        start = wr_ptr;
        all_gone = 0;
        placed = 0;
        for (int pass = 0; pass < MAX_PASSES && !placed; pass++) begin
            fr = get32(longint'(wr_ptr) + 4);
            if (fr >= need) begin
                nxt = longint'(wr_ptr) + HDR_BYTES + len;
                for (int unsigned i = 0; i < len; i++)
                    ring_mem[(longint'(wr_ptr) + HDR_BYTES + i) % BUFFER_BYTES] = stage_mem[i];
                put32(wr_ptr, len);
                put32(nxt, 0);
                put32(nxt + 4, fr - need);
                put32(longint'(wr_ptr) + 4, 0);
                wr_ptr = (nxt >= BUFFER_BYTES) ? 0 : int'(nxt);
                placed = 1;
            end else begin
                for (int steps = 0; fr < need && steps < BUFFER_BYTES; steps++) begin
                    nx = longint'(wr_ptr) + HDR_BYTES + get32(wr_ptr) + fr;
                    if (nx == start) all_gone = 1;
                    if (nx >= BUFFER_BYTES) break;
                    fr += HDR_BYTES + get32(nx) + get32(nx + 4);
                    put32(longint'(wr_ptr) + 4, fr);
                end
                if (fr < need) begin
                    // ran off the end: wrap and reuse the first block
                    wr_ptr = 0;
                    put32(4, get32(4) + get32(0));
                    put32(0, 0);
                end
            end
        end
        if (!placed) return 0;
        e = block_end(wr_ptr);
        np = (e >= BUFFER_BYTES) ? 0 : int'(e);
        for (int i = 0; i < READERS; i++) begin
            p = cursor[i];
            if (all_gone)
                cursor[i] = np;
            else if (np > start) begin
                if (p > start && p < np) cursor[i] = np;
            end else if (p > start || p < np)
                cursor[i] = np;
        end
        return 1;
    endfunction

    function automatic void read_next(int unsigned rid, int unsigned cap);
        int unsigned     pos, len, np, steps, cnt;
        longint unsigned e;
        logic [63:0]     d;
        pos = cursor[rid];
        if (pos == wr_ptr) begin
            push_resp(ST_NO_DATA, '0, '0, '0, '0, 1'b1);
            return;
        end
        steps = 0;
        while (get32(pos) == 0) begin
            if (pos == wr_ptr || steps >= BUFFER_BYTES) begin
                push_resp(ST_NO_DATA, '0, '0, '0, '0, 1'b1);
                return;
            end
            e = block_end(pos);
            pos = (e >= BUFFER_BYTES) ? 0 : int'(e);
            steps++;
        end
        len = get32(pos);
        e = block_end(pos);
        np = (e >= BUFFER_BYTES) ? 0 : int'(e);
        if (len > cap || len > MAX_RECORD) begin
            cursor[rid] = np;
            push_resp(ST_TOO_LONG, '0, len[9:0], '0, '0, 1'b1);
            return;
        end
        for (int unsigned off = 0; off < len; off += 8) begin
            cnt = (len - off < 8) ? len - off : 8;
            d = '0;
            for (int unsigned b = 0; b < cnt; b++)
                d[8*b +: 8] = ring_mem[(longint'(pos) + HDR_BYTES + off + b) % BUFFER_BYTES];
            push_resp(ST_DATA, '0, len[9:0], d, cnt[3:0], (off + 8 >= len));
        end
        cursor[rid] = np;
    endfunction

    function automatic void predict_ring(cmd_t c);
        logic [3:0] st;
        bit         found;
        case (c.action)
            ACT_APPEND: begin
                st = ST_APPENDED;
                if (c.has_byte) begin
                    if (stage_cnt < MAX_RECORD) begin
                        stage_mem[stage_cnt] = c.data_byte;
                        stage_cnt++;
                    end else
                        stage_ovf = 1;
                end
                if (c.last_byte) begin
                    if (stage_ovf || stage_cnt + 2 * HDR_BYTES > BUFFER_BYTES)
                        st = ST_DROPPED;
                    else if (!place_staged(stage_cnt))
                        st = ST_DROPPED;
                    stage_cnt = 0;
                    stage_ovf = 0;
                end
                push_resp(st, '0, '0, '0, '0, 1'b1);
            end
            ACT_CLAIM: begin
                found = 0;
                for (int i = 0; i < READERS && !found; i++) begin
                    if (!claimed_mask[i]) begin
                        claimed_mask[i] = 1'b1;
                        cursor[i] = wr_ptr;
                        push_resp(ST_GRANTED, i[2:0], '0, '0, '0, 1'b1);
                        found = 1;
                    end
                end
                if (!found) push_resp(ST_NONE_FREE, '0, '0, '0, '0, 1'b1);
            end
            ACT_RELEASE: begin
                if (c.reader_id >= READERS)
                    push_resp(ST_BAD_READER, '0, '0, '0, '0, 1'b1);
                else begin
                    claimed_mask[c.reader_id] = 1'b0;
                    push_resp(ST_RELEASED, '0, '0, '0, '0, 1'b1);
                end
            end
            ACT_READ: begin
                if (c.reader_id >= READERS)
                    push_resp(ST_BAD_READER, '0, '0, '0, '0, 1'b1);
                else
                    read_next(c.reader_id, c.read_capacity);
            end
            ACT_CLEAR: begin
                wipe_ring();
                push_resp(ST_CLEARED, '0, '0, '0, '0, 1'b1);
            end
            default: ;  // undefined actions are ignored
        endcase
    endfunction

    function automatic cmd_t mk(logic [2:0] act, logic [7:0] b = '0, logic hb = 1'b0,
                                logic lb = 1'b0, logic [2:0] rid = '0,
                                logic [9:0] cap = '0);
        cmd_t c;
        c = '{action: act, data_byte: b, has_byte: hb, last_byte: lb,
              reader_id: rid, read_capacity: cap};
        return c;
    endfunction

    // queue a whole record; the closing transaction may or may not carry a byte
    task automatic add_record(int len, bit random_bytes);
        bit close_empty;
        close_empty = (len == 0) || ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++) begin
            if (i == len - 1 && !close_empty)
                pending_cmds.push_back(mk(ACT_APPEND, random_bytes ? 8'($urandom) : 8'(i),
                                          1'b1, 1'b1));
            else
                pending_cmds.push_back(mk(ACT_APPEND, random_bytes ? 8'($urandom) : 8'(i),
                                          1'b1, 1'b0));
        end
        if (close_empty) pending_cmds.push_back(mk(ACT_APPEND, 8'($urandom), 1'b0, 1'b1));
    endtask

    // stimulus
    initial begin
        int len;
        int pick;
        // directed part
        pending_cmds.push_back(mk(ACT_CLAIM));
        pending_cmds.push_back(mk(ACT_READ, 8'd0, 1'b0, 1'b0, 3'd0, 10'd512));
        add_record(13, 0);
        pending_cmds.push_back(mk(ACT_APPEND, 8'hff, 1'b0, 1'b1));   // empty record
        add_record(3, 1);
        pending_cmds.push_back(mk(ACT_READ, 8'd0, 1'b0, 1'b0, 3'd0, 10'd1023));
        pending_cmds.push_back(mk(ACT_READ, 8'd0, 1'b0, 1'b0, 3'd0, 10'd0)); // too little room
        pending_cmds.push_back(mk(ACT_READ, 8'd0, 1'b0, 1'b0, 3'd0, 10'd3));
        pending_cmds.push_back(mk(ACT_READ, 8'd0, 1'b0, 1'b0, 3'd7, 10'd512)); // unclaimed
        for (int i = 0; i < READERS + 1; i++) pending_cmds.push_back(mk(ACT_CLAIM));
        pending_cmds.push_back(mk(ACT_RELEASE, 8'd0, 1'b0, 1'b0, 3'd7));
        pending_cmds.push_back(mk(ACT_RELEASE, 8'd0, 1'b0, 1'b0, 3'd5));
        pending_cmds.push_back(mk(3'd5));
        pending_cmds.push_back(mk(3'd6));
        pending_cmds.push_back(mk(3'd7, 8'hff, 1'b1, 1'b1, 3'd7, 10'h3ff));
        pending_cmds.push_back(mk(ACT_APPEND, 8'h5a, 1'b1, 1'b0));
        pending_cmds.push_back(mk(ACT_CLEAR));                       // drops staged byte
        pending_cmds.push_back(mk(ACT_CLAIM));
        add_record(9, 1);
        pending_cmds.push_back(mk(ACT_READ, 8'd0, 1'b0, 1'b0, 3'd0, 10'd512));

        // random part: mostly short records and reads, some noise
        while (pending_cmds.size() < ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                len = ($urandom_range(0, 9) == 0) ? int'($urandom_range(13, 24))
                                                 : int'($urandom_range(0, 8));
                add_record(len, 1);
            end else if (pick < 80)
                pending_cmds.push_back(mk(ACT_READ, 8'($urandom), 1'($urandom),
                    1'($urandom), 3'($urandom_range(0, 7)),
                    ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
                                               : 10'($urandom_range(0, 64))));
            else if (pick < 88)
                pending_cmds.push_back(mk(ACT_CLAIM, 8'($urandom), 1'($urandom),
                                          1'($urandom), 3'($urandom), 10'($urandom)));
            else if (pick < 95)
                pending_cmds.push_back(mk(ACT_RELEASE, 8'($urandom), 1'($urandom),
                                          1'($urandom), 3'($urandom_range(0, 7)),
                                          10'($urandom)));
            else if (pick < 97)
                pending_cmds.push_back(mk(ACT_CLEAR, 8'($urandom), 1'($urandom),
                                          1'($urandom), 3'($urandom), 10'($urandom)));
            else
                pending_cmds.push_back(mk(3'($urandom_range(5, 7)), 8'($urandom),
                                          1'($urandom), 1'($urandom), 3'($urandom),
                                          10'($urandom)));
        end
    end

    // reset and end of run
    initial begin
        error_count = 0;
        for (int i = 0; i < BUFFER_BYTES; i++) ring_mem[i] = 8'h00;
        for (int i = 0; i < MAX_RECORD; i++) stage_mem[i] = 8'h00;
        wipe_ring();
        aresetn = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        wait (pending_cmds.size() == 0 && !s_tvalid && expected_resps.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && expected_resps.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // driver: bursts of transactions separated by random gaps
    int   burst_left;
    int   gap_left;
    cmd_t cur_cmd;

    always @(posedge aclk) begin
        logic nv;
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tuser    <= '0;
            s_tlast    <= 1'b0;
            burst_left <= 1;
            gap_left   <= 0;
        end else begin
            if (s_tvalid && s_tready) predict_ring(cur_cmd);
            if (s_tvalid && !s_tready)
                nv = 1'b1;
            else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                nv = 1'b0;
            end else if (pending_cmds.size() > 0) begin
                cur_cmd = pending_cmds.pop_front();
                s_tdata <= {2'b00, cur_cmd.read_capacity, cur_cmd.reader_id,
                            cur_cmd.has_byte, cur_cmd.data_byte};
                s_tuser <= cur_cmd.action;
                s_tlast <= cur_cmd.last_byte;
                nv = 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end else
                    burst_left <= burst_left - 1;
            end else
                nv = 1'b0;
            s_tvalid <= nv;
        end
    end

    // receiver stall pattern: alternating calm and choppy stretches
    int stall_phase;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready    <= 1'b0;
            stall_phase <= 0;
        end else begin
            stall_phase <= (stall_phase + 1) % 256;
            if (stall_phase < 64)
                m_tready <= 1'b1;
            else if (stall_phase < 192)
                m_tready <= ($urandom_range(0, 2) != 0);
            else
                m_tready <= ($urandom_range(0, 7) == 0);
        end
    end

    // monitor: compare each result transaction with the oldest expectation
    always @(posedge aclk) begin
        resp_t exp_r;
        resp_t act_r;
        if (aresetn && m_tvalid && m_tready) begin
            act_r = '{status: m_tuser, granted: m_tdata[2:0], rec_len: m_tdata[12:3],
                      payload: m_tdata[76:13], nbytes: m_tdata[80:77], last: m_tlast};
            if (expected_resps.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, act_r);
                error_count++;
            end else begin
                exp_r = expected_resps.pop_front();
                if (act_r.status !== exp_r.status)
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_r.status, act_r.status);
                if (act_r.granted !== exp_r.granted)
                    $display("%0t: granted_reader expected %0d actual %0d",
                             $time, exp_r.granted, act_r.granted);
                if (act_r.rec_len !== exp_r.rec_len)
                    $display("%0t: record_length expected %0d actual %0d",
                             $time, exp_r.rec_len, act_r.rec_len);
                if (act_r.payload !== exp_r.payload)
                    $display("%0t: out_data expected %h actual %h",
                             $time, exp_r.payload, act_r.payload);
                if (act_r.nbytes !== exp_r.nbytes)
                    $display("%0t: byte_count expected %0d actual %0d",
                             $time, exp_r.nbytes, act_r.nbytes);
                if (act_r.last !== exp_r.last)
                    $display("%0t: last_result expected %0d actual %0d",
                             $time, exp_r.last, act_r.last);
                if (act_r !== exp_r) error_count++;
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge aclk) begin
        if (!aresetn)
            idle_cycles <= 0;
        else if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

// ===== sim.f =====
sv/mrr_pkg.sv
sv/mrr_store.sv
sv/mrr_staging.sv
sv/multi_reader_record_ring_top.sv
bench/multi_reader_record_ring_top_tb.sv
